### rtl/rof_pkg.sv
// Shared types and constants for the recency ordered flag table.
// Holds table entry layout, operation codes, controller states and stream widths.
// No dependencies.
package rof_pkg;

  // Default number of table entries
  localparam int TABLE_DEPTH_DEFAULT = 8;

  // Field widths
  localparam int ID_W = 32;
  localparam int OP_W = 2;

  // Stream payload widths (padded to whole bytes)
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 8;

  // Operation codes; the unused code behaves as a query
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TOUCH  = 2'd2;

  // One table entry as stored in memory
  typedef struct packed {
    logic            flag;
    logic [ID_W-1:0] id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_t;

endpackage

### rtl/rof_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/recency_ordered_flag_table_core.sv
// Recency ordered flag table: top level, controller and entry memory.
// Depends on rof_pkg and rof_ram.
//
// Usage:
//   One operation enters per s_* transfer: s_tuser carries op, s_tdata
//   carries id, write_enable and write_value. Every operation returns
//   exactly one result on the m_* channel: found and active in m_tdata.
//   Entries live in one RAM ordered oldest (address 0) to newest
//   (address count-1). The controller reads entries one per cycle to
//   find the id, then moves the newer entries down one slot per cycle to
//   close a gap, and writes a touched id at the newest position.
//   An operation scans the entries up to the match or all of them (at
//   least one position); a remove, a touch of a present id or a touch
//   that evicts the oldest entry then adds one shift step per entry from
//   the matched position up to the newest. The longest operation on a
//   full table is a touch of an absent id that evicts. m_tvalid rises
//   after the scan, any shift steps and the finish state, once the
//   output register is free. The single RAM port pair (one read, one
//   write per cycle) sets the pace of the scan and shift steps.
//   One operation is in work at a time; s_tready is high while idle.
//   The result sits in an output register, so a new operation is taken
//   while m_tvalid waits on m_tready; its result then holds until the
//   register frees up.
//   Reset empties the table (entry count zero); memory needs no clearing.
module recency_ordered_flag_table_core
  import rof_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [31:0] id, [32] write_enable, [33] write_value, [39:34] zero
  input  logic [S_DATA_W-1:0] s_tdata,
  // [1:0] op
  input  logic [OP_W-1:0]     s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] found, [1] active, [7:2] zero
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  // Operation registers
  logic [OP_W-1:0] op_q;
  logic [ID_W-1:0] key_q;
  logic            we_q;
  logic            wv_q;

  // Control and working registers
  logic [CW-1:0] cnt, cnt_next;
  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] widx, widx_next;
  logic          flag_q, flag_next;
  logic          res_found, res_found_next;
  logic          res_active, res_active_next;
  logic                m_tvalid_next;
  logic [M_DATA_W-1:0] m_tdata_next;

  // RAM port signals
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;

  // Decode helpers
  logic s_acc;
  logic out_free;
  logic is_touch;
  logic is_remove;
  logic cnt_nz;
  logic hit;
  logic at_end;
  logic full;
  logic widx_last;
  logic new_flag;

  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign is_touch  = (op_q == OP_TOUCH);
  assign is_remove = (op_q == OP_REMOVE);
  assign cnt_nz    = (cnt != '0);
  assign hit       = cnt_nz && (ram_rdata.id == key_q);
  assign at_end    = !cnt_nz || (CW'(idx) == cnt - CW'(1));
  assign full      = (cnt == CW'(TABLE_DEPTH));
  assign widx_last = (CW'(widx) == cnt - CW'(1));
  // Flag a touched entry ends with, including the optional flag write
  assign new_flag  = we_q ? wv_q : (hit ? ram_rdata.flag : 1'b1);

  // Entry memory
  rof_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = (is_touch || is_remove) ? ST_SHIFT : ST_FINISH;
        end else if (at_end) begin
          state_next = (is_touch && full) ? ST_SHIFT : ST_FINISH;
        end
      end
      ST_SHIFT: begin
        if (widx_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory access and working register updates
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = widx;
    ram_wdata       = '{flag: flag_q, id: key_q};
    ram_raddr       = '0;
    cnt_next        = cnt;
    idx_next        = idx;
    widx_next       = widx;
    flag_next       = flag_q;
    res_found_next  = res_found;
    res_active_next = res_active;
    case (state)
      ST_IDLE: begin
        // Start the scan at the oldest entry
        ram_raddr = '0;
        idx_next  = '0;
      end
      ST_SCAN: begin
        // Prefetch the next entry; it also feeds the first shift step
        ram_raddr = idx + IW'(1);
        if (hit) begin
          res_found_next  = 1'b1;
          widx_next       = idx;
          flag_next       = new_flag;
          if (is_remove) begin
            res_active_next = 1'b0;
          end else if (is_touch) begin
            res_active_next = new_flag;
          end else begin
            res_active_next = ram_rdata.flag;
          end
        end else if (at_end) begin
          res_found_next  = 1'b0;
          res_active_next = is_touch ? new_flag : 1'b0;
          flag_next       = new_flag;
          if (is_touch) begin
            if (!full) begin
              // Append at the newest position
              ram_we    = 1'b1;
              ram_waddr = cnt[IW-1:0];
              ram_wdata = '{flag: new_flag, id: key_q};
              cnt_next  = cnt + CW'(1);
            end else begin
              // Evict the oldest entry: shift from address zero
              ram_raddr = IW'(1);
              widx_next = '0;
            end
          end
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      ST_SHIFT: begin
        if (widx_last) begin
          if (is_remove) begin
            cnt_next = cnt - CW'(1);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = widx;
            ram_wdata = '{flag: flag_q, id: key_q};
          end
        end else begin
          // Move the newer entry down one slot
          ram_we    = 1'b1;
          ram_waddr = widx;
          ram_wdata = ram_rdata;
          ram_raddr = widx + IW'(2);
          widx_next = widx + IW'(1);
        end
      end
      ST_FINISH: begin
        ram_raddr = '0;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  // Output register
  always_comb begin
    m_tvalid_next = m_tvalid;
    m_tdata_next  = m_tdata;
    if (state == ST_FINISH && out_free) begin
      m_tvalid_next = 1'b1;
      m_tdata_next  = {{(M_DATA_W - 2){1'b0}}, res_active, res_found};
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      op_q  <= s_tuser;
      key_q <= s_tdata[31:0];
      we_q  <= s_tdata[32];
      wv_q  <= s_tdata[33];
    end
    idx        <= idx_next;
    widx       <= widx_next;
    flag_q     <= flag_next;
    res_found  <= res_found_next;
    res_active <= res_active_next;
    m_tdata    <= m_tdata_next;
  end

endmodule

### bench/tb_top.sv
// Self-checking bench for recency_ordered_flag_table_core.
// Mirrors the table contents and recency order in a local model; depends on rof_pkg.
// Runs directed cases first, then random query/remove/touch traffic, with stalls on both streams in some runs.
module tb_top;
  import rof_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEFAULT;
  // Unused operation code; the block treats it as a query
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic found;
    logic active;
  } flag_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // [31:0] id, [32] write_enable, [33] write_value, [39:34] zero
  logic [S_DATA_W-1:0] s_tdata = '0;
  // [1:0] op
  logic [OP_W-1:0]     s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // [0] found, [1] active, [7:2] zero
  logic [M_DATA_W-1:0] m_tdata;

  // Local copy of the table, oldest entry at index 0
  logic [ID_W-1:0] model_ids[DEPTH];
  logic            model_flags[DEPTH];
  int              model_count = 0;

  flag_result_t    pending_results[$];
  logic [ID_W-1:0] id_pool[$];
  int              fail_count = 0;
  int              sink_hold_left = 0;
  bit              src_gaps_on = 1'b1;
  bit              sink_stalls_on = 1'b1;

  recency_ordered_flag_table_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Close the hole at pos by moving newer entries down one slot
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < model_count; i++) begin
      model_ids[i]   = model_ids[i + 1];
      model_flags[i] = model_flags[i + 1];
    end
    model_count--;
  endfunction

  // Apply one operation to the local table and return its result
  function automatic flag_result_t apply_table_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                                  logic we, logic wv);
    flag_result_t res;
    int           slot;
    logic         flag;
    slot = -1;
    for (int i = 0; i < model_count; i++) begin
      if (slot < 0 && model_ids[i] == id) slot = i;
    end
    res.found  = (slot >= 0);
    res.active = 1'b0;
    case (op)
      OP_REMOVE: begin
        if (slot >= 0) drop_entry(slot);
      end
      OP_TOUCH: begin
        if (slot >= 0) begin
          flag = model_flags[slot];
          drop_entry(slot);
        end else begin
          flag = 1'b1;
          if (model_count >= DEPTH) drop_entry(0);
        end
        if (we) flag = wv;
        model_ids[model_count]   = id;
        model_flags[model_count] = flag;
        model_count++;
        res.active = flag;
      end
      default: begin
        if (slot >= 0) res.active = model_flags[slot];
      end
    endcase
    return res;
  endfunction

  // Offer one operation and hold it until the transfer completes
  task automatic send_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic we = 1'b0,
                         logic wv = 1'b0);
    int gap;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, wv, we, id};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    pending_results.insert(pending_results.size(), apply_table_op(op, id, we, wv));
  endtask

  // Stall the result stream at random
  always @(posedge clk) begin
    if (sink_hold_left > 0) begin
      sink_hold_left <= sink_hold_left - 1;
      m_tready <= 1'b0;
    end else if (!sink_stalls_on || $urandom_range(0, 3) != 0) begin
      m_tready <= 1'b1;
    end else begin
      sink_hold_left <= pick_gap();
      m_tready <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    flag_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: m_tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (m_tdata[0] !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, m_tdata[0]);
          fail_count++;
        end
        if (m_tdata[1] !== want.active) begin
          $error("active: expected %0b, actual %0b", want.active, m_tdata[1]);
          fail_count++;
        end
      end
    end
  end

  // Operations on the empty table after reset
  task automatic test_empty_table();
    send_op(OP_QUERY, 32'h0000_0000);
    send_op(OP_SPARE, 32'h5A5A_5A5A, 1'b1, 1'b1);
    send_op(OP_REMOVE, 32'hFFFF_FFFF);
  endtask

  // Touch with and without flag writes, query, spare code and remove
  task automatic test_touch_and_flags();
    send_op(OP_TOUCH, 32'h0000_0000);
    send_op(OP_TOUCH, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_op(OP_QUERY, 32'hFFFF_FFFF);
    send_op(OP_TOUCH, 32'hFFFF_FFFF);
    send_op(OP_TOUCH, 32'h0000_0000, 1'b1, 1'b0);
    send_op(OP_TOUCH, 32'h0000_0000, 1'b1, 1'b1);
    send_op(OP_SPARE, 32'h0000_0000);
    send_op(OP_REMOVE, 32'hFFFF_FFFF);
    send_op(OP_REMOVE, 32'hFFFF_FFFF);
    send_op(OP_REMOVE, 32'h0000_0000);
  endtask

  // Fill the table, evict the oldest, then move and remove inside a full table
  task automatic test_full_table();
    for (int i = 0; i < DEPTH; i++) send_op(OP_TOUCH, 32'h100 + i);
    send_op(OP_TOUCH, 32'h100 + DEPTH);
    send_op(OP_QUERY, 32'h100);
    send_op(OP_TOUCH, 32'h101);
    send_op(OP_REMOVE, 32'h104);
    send_op(OP_QUERY, 32'h100 + DEPTH - 1);
  endtask

  // Random traffic over a pool of ids, with occasional fully random ids
  task automatic test_random_traffic(int n_ops, int pool_size, bit gaps, bit stalls);
    int              r;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    src_gaps_on    = gaps;
    sink_stalls_on = stalls;
    id_pool.delete();
    for (int i = 0; i < pool_size; i++) id_pool.insert(id_pool.size(), $urandom());
    for (int n = 0; n < n_ops; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      op = OP_TOUCH;
      else if (r < 75) op = OP_QUERY;
      else if (r < 95) op = OP_REMOVE;
      else             op = OP_SPARE;
      if ($urandom_range(0, 9) == 0) id = $urandom();
      else id = id_pool[$urandom_range(0, pool_size - 1)];
      send_op(op, id, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_touch_and_flags();
    test_full_table();
    test_random_traffic(300, 6, 1'b1, 1'b1);
    test_random_traffic(300, 12, 1'b0, 1'b0);
    test_random_traffic(300, 10, 1'b1, 1'b1);
    test_random_traffic(200, 24, 1'b1, 1'b0);
    s_tvalid <= 1'b0;
    // Drain, then leave room for any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * DEPTH + 40) @(posedge clk);
    if (fail_count == 0) begin
      $display("recency_ordered_flag_table_core: match");
    end else begin
      $display("recency_ordered_flag_table_core: mismatch");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #20_000_000;
    $display("recency_ordered_flag_table_core: mismatch");
    $finish;
  end

endmodule
